### design/bpr_pkg.sv
// shared types, constants and codes of the bmp pixel row decoder
package bpr_pkg;

    // image limits
    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 4096;

    // palette
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);
    localparam int PAL_BITS    = 24;

    // queues
    localparam int JOBQ_DEPTH = 4;
    localparam int JQ_AW      = $clog2(JOBQ_DEPTH);
    localparam int OUTQ_DEPTH = 4;
    localparam int OQ_AW      = $clog2(OUTQ_DEPTH);

    // command codes
    localparam logic [1:0] CMD_PAL   = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DEPTH  = 2'd2;

    // indexed depth codes
    localparam logic [1:0] DC_1 = 2'd0;
    localparam logic [1:0] DC_2 = 2'd1;
    localparam logic [1:0] DC_4 = 2'd2;
    localparam logic [1:0] DC_8 = 2'd3;

    // one unit of work for the back end: a palette write, a byte's pixels or one direct 24-bit pixel
    typedef struct packed {
        logic        is_write;
        logic        direct;
        logic [1:0]  dcode;
        logic [7:0]  byte_val;
        logic [23:0] color;
        logic [11:0] col;
        logic [11:0] row;
        logic [3:0]  cnt;
    } t_job;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] col;
        logic [11:0] row;
        logic        last;
    } t_pix;

endpackage

### design/bpr_ram.sv
// generic single write port, single read port ram with registered read
module bpr_ram #(
    parameter int P_WIDTH = 24,
    parameter int P_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]         i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/bpr_front.sv
// front end: configuration registers, command decode and row/column tracking
module bpr_front import bpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_accept,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_palette_index,
    input  logic [23:0] i_palette_value,
    output logic        o_job_valid,
    output t_job        o_job
);

    logic [12:0] r_width, r_height;
    logic [4:0]  r_bpp;
    logic [12:0] r_col, n_col;
    logic [12:0] r_row, n_row;
    logic [1:0]  r_rbp, n_rbp;
    logic [1:0]  r_cph, n_cph;
    logic [15:0] r_part, n_part;
    logic        r_done, n_done;

    logic [12:0] weff, heff, rem;
    logic        supported, is24;
    logic [1:0]  dcode;
    logic [3:0]  ppb, nsub;
    logic [12:0] row_pos;

    // effective geometry
    always_comb begin
        if (r_width == 13'd0)                weff = 13'd1;
        else if (r_width > 13'(MAX_WIDTH))   weff = 13'(MAX_WIDTH);
        else                                 weff = r_width;
        if (r_height == 13'd0)               heff = 13'd1;
        else if (r_height > 13'(HEIGHT_LIMIT)) heff = 13'(HEIGHT_LIMIT);
        else                                 heff = r_height;
    end

    always_comb begin
        supported = 1'b1;
        is24      = 1'b0;
        dcode     = DC_8;
        ppb       = 4'd1;
        unique case (r_bpp)
            5'd1:    begin dcode = DC_1; ppb = 4'd8; end
            5'd2:    begin dcode = DC_2; ppb = 4'd4; end
            5'd4:    begin dcode = DC_4; ppb = 4'd2; end
            5'd8:    begin dcode = DC_8; ppb = 4'd1; end
            5'd24:   is24 = 1'b1;
            default: supported = 1'b0;
        endcase
    end

    assign rem     = weff - r_col;
    assign nsub    = (rem < {9'd0, ppb}) ? rem[3:0] : ppb;
    assign row_pos = heff - 13'd1 - r_row;

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_rbp       = r_rbp;
        n_cph       = r_cph;
        n_part      = r_part;
        n_done      = r_done;
        o_job_valid = 1'b0;
        o_job       = '0;
        o_job.col   = r_col[11:0];
        o_job.row   = row_pos[11:0];
        o_job.dcode = dcode;
        o_job.byte_val = i_data_byte;
        if (i_accept) begin
            unique case (i_cmd)
                CMD_PAL: begin
                    o_job_valid     = 1'b1;
                    o_job.is_write  = 1'b1;
                    o_job.byte_val  = i_palette_index;
                    o_job.color     = i_palette_value;
                end
                CMD_START: begin
                    n_col  = '0;
                    n_row  = '0;
                    n_rbp  = '0;
                    n_cph  = '0;
                    n_part = '0;
                    n_done = 1'b0;
                end
                CMD_DATA: begin
                    if (!r_done) begin
                        if (r_row >= heff) begin
                            n_done = 1'b1;
                        end else if (supported) begin
                            if (r_col < weff) begin
                                if (is24) begin
                                    if (r_cph == 2'd0) begin
                                        n_part = {8'd0, i_data_byte};
                                        n_cph  = 2'd1;
                                    end else if (r_cph == 2'd1) begin
                                        n_part = {i_data_byte, r_part[7:0]};
                                        n_cph  = 2'd2;
                                    end else begin
                                        o_job_valid  = 1'b1;
                                        o_job.direct = 1'b1;
                                        o_job.color  = {i_data_byte, r_part};
                                        o_job.cnt    = 4'd1;
                                        n_col        = r_col + 13'd1;
                                        n_cph        = 2'd0;
                                    end
                                end else begin
                                    o_job_valid = 1'b1;
                                    o_job.cnt   = nsub;
                                    n_col       = r_col + {9'd0, nsub};
                                end
                            end
                            n_rbp = r_rbp + 2'd1;
                            // row ends once the columns are filled and the row's byte count is a multiple of four
                            if (n_col >= weff && n_rbp == 2'd0) begin
                                n_col  = '0;
                                n_cph  = '0;
                                n_part = '0;
                                n_row  = r_row + 13'd1;
                                if (r_row + 13'd1 >= heff) begin
                                    n_done = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1;
            r_height <= 13'd1;
            r_bpp    <= 5'd24;
            r_col    <= '0;
            r_row    <= '0;
            r_rbp    <= '0;
            r_cph    <= '0;
            r_part   <= '0;
            r_done   <= 1'b1;
        end else begin
            if (i_cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    CFG_DEPTH:  r_bpp    <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            r_col  <= n_col;
            r_row  <= n_row;
            r_rbp  <= n_rbp;
            r_cph  <= n_cph;
            r_part <= n_part;
            r_done <= n_done;
        end
    end

    a_job_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && !o_job.is_write |-> o_job.cnt != 4'd0 && o_job.cnt <= 4'd8)
        else $error("pixel job with bad pixel count");

endmodule

### design/bpr_jobq.sv
// short job queue between front and back end
module bpr_jobq import bpr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job             r_q [JOBQ_DEPTH];
    logic [JQ_AW-1:0] r_wp, r_rp;
    logic [JQ_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (JQ_AW+1)'(JOBQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (JQ_AW+1)'(i_push) - (JQ_AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("job queue overflow");

endmodule

### design/bpr_back.sv
// back end: palette store, pixel unpacking and result queue
module bpr_back import bpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output t_pix        o_pix
);

    // working job
    logic        r_busy;
    logic        r_direct;
    logic [1:0]  r_dcode;
    logic [7:0]  r_byte;
    logic [23:0] r_color;
    logic [11:0] r_col, r_row;
    logic [3:0]  r_left;

    // lookup stage
    logic        r_s1_valid;
    logic        r_s1_direct, r_s1_black, r_s1_last;
    logic [23:0] r_s1_color;
    logic [11:0] r_s1_col, r_s1_row;

    // result queue
    t_pix             r_oq [OUTQ_DEPTH];
    logic [OQ_AW-1:0] r_owp, r_orp;
    logic [OQ_AW:0]   r_ocnt;

    logic [OQ_AW:0]     occ;
    logic               can_issue, finishing, load, black, rd_en, wr_en, out_pop;
    logic [7:0]         idx;
    logic [7:0]         byte_next;
    logic [PAL_BITS-1:0] rd_data;
    t_pix               pix_in;

    assign occ       = r_ocnt + (OQ_AW+1)'(r_s1_valid);
    assign can_issue = r_busy && (occ < (OQ_AW+1)'(OUTQ_DEPTH));
    assign finishing = can_issue && (r_left == 4'd1);
    assign load      = i_q_valid && (!r_busy || finishing);
    assign o_q_pop   = load;

    // top bits of the working byte are the next palette index
    always_comb begin
        unique case (r_dcode)
            DC_1:    begin idx = {7'd0, r_byte[7]};   byte_next = {r_byte[6:0], 1'b0}; end
            DC_2:    begin idx = {6'd0, r_byte[7:6]}; byte_next = {r_byte[5:0], 2'b0}; end
            DC_4:    begin idx = {4'd0, r_byte[7:4]}; byte_next = {r_byte[3:0], 4'b0}; end
            default: begin idx = r_byte;              byte_next = r_byte;              end
        endcase
    end

    assign black = ({1'b0, idx} >= 9'(PAL_ENTRIES));
    assign rd_en = can_issue && !r_direct && !black;
    assign wr_en = load && i_q_job.is_write && ({1'b0, i_q_job.byte_val} < 9'(PAL_ENTRIES));

    bpr_ram #(
        .P_WIDTH (PAL_BITS),
        .P_DEPTH (PAL_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_q_job.byte_val[PAL_AW-1:0]),
        .i_wr_data (i_q_job.color),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx[PAL_AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (load && !i_q_job.is_write) begin
                r_busy <= 1'b1;
            end else if (finishing) begin
                r_busy <= 1'b0;
            end
            r_s1_valid <= can_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_q_job.is_write) begin
            r_direct <= i_q_job.direct;
            r_dcode  <= i_q_job.dcode;
            r_byte   <= i_q_job.byte_val;
            r_color  <= i_q_job.color;
            r_col    <= i_q_job.col;
            r_row    <= i_q_job.row;
            r_left   <= i_q_job.cnt;
        end else if (can_issue) begin
            r_byte <= byte_next;
            r_col  <= r_col + 12'd1;
            r_left <= r_left - 4'd1;
        end
        if (can_issue) begin
            r_s1_direct <= r_direct;
            r_s1_black  <= black;
            r_s1_last   <= (r_left == 4'd1);
            r_s1_color  <= r_color;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
        end
    end

    // result assembly
    always_comb begin
        pix_in.col  = r_s1_col;
        pix_in.row  = r_s1_row;
        pix_in.last = r_s1_last;
        if (r_s1_direct) begin
            {pix_in.red, pix_in.green, pix_in.blue} = r_s1_color;
        end else if (r_s1_black) begin
            {pix_in.red, pix_in.green, pix_in.blue} = '0;
        end else begin
            {pix_in.red, pix_in.green, pix_in.blue} = rd_data;
        end
    end

    assign o_empty = (r_ocnt == '0);
    assign out_pop = i_pop && !o_empty;
    assign o_pix   = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_oq[r_owp] <= pix_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_s1_valid) r_owp <= r_owp + 1'b1;
            if (out_pop)    r_orp <= r_orp + 1'b1;
            r_ocnt <= r_ocnt + (OQ_AW+1)'(r_s1_valid) - (OQ_AW+1)'(out_pop);
        end
    end

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> r_ocnt < (OQ_AW+1)'(OUTQ_DEPTH))
        else $error("lookup result has no room in result queue");

    a_busy_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_left != 4'd0)
        else $error("working job with no pixels left");

    a_issue_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        can_issue |=> r_s1_valid)
        else $error("issued pixel lost before result queue");

endmodule

### design/bmp_pixel_row_decoder.sv
// top level of the bmp pixel row decoder
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ---------------------------------
//  input     in         push / full (push & !full)    cmd, data_byte, palette_index/value
//  result    out        empty / pop (pop & !empty)    red, green, blue, column, row, last
//  config    in         cfg_valid / cfg_ready         cfg_index, cfg_data
//
//  the front end takes one item per cycle while the job queue has room
//  the back end emits one pixel per cycle while the result queue has room;
//  depths 1, 2 and 4 give up to 8, 4 and 2 pixels per byte, so a byte takes
//  that many palette reads, and input stalls through full once the job queue fills
//  a byte's first pixel goes through the job queue, issue and palette read in that order
//  synchronous active-low reset clears counters and queues; palette keeps
//  its contents and is undefined until written
//  a stalled pop holds results in a four-entry result queue, issue waits on its credit
module bmp_pixel_row_decoder import bpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_palette_index,
    input  logic [23:0] i_palette_value,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [11:0] o_column,
    output logic [11:0] o_row,
    output logic        o_last,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic accept;
    logic job_valid, q_valid, q_pop, q_full;
    t_job job, q_job;
    t_pix pix;

    // config registers are always writable
    assign o_cfg_ready = 1'b1;

    // an input transfer happens when push is high and the job queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    bpr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_cmd           (i_cmd),
        .i_data_byte     (i_data_byte),
        .i_palette_index (i_palette_index),
        .i_palette_value (i_palette_value),
        .o_job_valid     (job_valid),
        .o_job           (job)
    );

    // palette writes ride the same queue so lookups see them in order
    bpr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    bpr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_pix     (pix)
    );

    assign o_red    = pix.red;
    assign o_green  = pix.green;
    assign o_blue   = pix.blue;
    assign o_column = pix.col;
    assign o_row    = pix.row;
    assign o_last   = pix.last;

endmodule
